>>> sv/hsa_pkg.sv
// ----------------------------------------------------------------------------
// HSL saturation adjust package
// Shared pixel sideband type and fixed-point constants.
// ----------------------------------------------------------------------------
package hsa_pkg;

    localparam int CH_W      = 8;
    localparam int SUM_W     = 9;
    localparam int SQ_W      = 17;
    localparam int INV_W     = 24;
    localparam int SNUM_W    = 24;
    localparam int INUM_W    = 33;

    localparam logic signed [7:0] INC_MAX   = 8'sd100;
    localparam logic signed [7:0] INC_MIN   = -8'sd100;
    localparam logic signed [7:0] INC_RESET = 8'sd50;
    localparam logic [7:0]        F_RESET   = 8'd150;
    localparam logic [SQ_W-1:0]   T_RESET   = 17'd32768;

    typedef struct packed {
        logic [CH_W-1:0]  b;
        logic [CH_W-1:0]  g;
        logic [CH_W-1:0]  r;
        logic [SUM_W-1:0] sum;
        logic             gray;
        logic [CH_W-1:0]  nb;
        logic [CH_W-1:0]  ng;
        logic [CH_W-1:0]  nr;
    } pix_t;

endpackage

>>> sv/hsa_div_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage; sideband data travels alongside.
// ----------------------------------------------------------------------------
module hsa_div_pipe
    import hsa_pkg::*;
#(
    parameter int NUM_W = 24,
    parameter int DEN_W = 8,
    parameter int QUO_W = 17,
    parameter int SB_W  = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  logic [SB_W-1:0]  in_sb,
    output logic             out_valid,
    output logic [QUO_W-1:0] out_quo,
    output logic [SB_W-1:0]  out_sb
);

    logic             valid_reg [QUO_W];
    logic [DEN_W-1:0] rem_reg   [QUO_W];
    logic [QUO_W-1:0] lo_reg    [QUO_W];
    logic [QUO_W-1:0] quo_reg   [QUO_W];
    logic [DEN_W-1:0] den_reg   [QUO_W];
    logic [SB_W-1:0]  sb_reg    [QUO_W];

    logic             valid_src [QUO_W];
    logic [DEN_W-1:0] rem_src   [QUO_W];
    logic [QUO_W-1:0] lo_src    [QUO_W];
    logic [QUO_W-1:0] quo_src   [QUO_W];
    logic [DEN_W-1:0] den_src   [QUO_W];
    logic [SB_W-1:0]  sb_src    [QUO_W];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++)
        begin : g_stage
            logic [DEN_W:0]   trial;
            logic             ge;
            logic [DEN_W:0]   diff;

            if (k == 0)
            begin : g_first
                assign valid_src[k] = in_valid;
                assign rem_src[k]   = DEN_W'(in_num[NUM_W-1:QUO_W]);
                assign lo_src[k]    = in_num[QUO_W-1:0];
                assign quo_src[k]   = '0;
                assign den_src[k]   = in_den;
                assign sb_src[k]    = in_sb;
            end
            else
            begin : g_next
                assign valid_src[k] = valid_reg[k-1];
                assign rem_src[k]   = rem_reg[k-1];
                assign lo_src[k]    = lo_reg[k-1];
                assign quo_src[k]   = quo_reg[k-1];
                assign den_src[k]   = den_reg[k-1];
                assign sb_src[k]    = sb_reg[k-1];
            end

            assign trial = {rem_src[k], lo_src[k][QUO_W-1]};
            assign ge    = (trial >= {1'b0, den_src[k]});
            assign diff  = trial - {1'b0, den_src[k]};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else
                begin
                    valid_reg[k] <= valid_src[k];
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                lo_reg[k]  <= {lo_src[k][QUO_W-2:0], 1'b0};
                quo_reg[k] <= {quo_src[k][QUO_W-2:0], ge};
                den_reg[k] <= den_src[k];
                sb_reg[k]  <= sb_src[k];
            end
        end
    endgenerate

    assign out_valid = valid_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_sb    = sb_reg[QUO_W-1];

endmodule

>>> sv/hsa_front.sv
// ----------------------------------------------------------------------------
// HSL saturation adjust front end
// Max, min, lightness terms, the gray-scaling branch and the saturation dividend.
// ----------------------------------------------------------------------------
module hsa_front
    import hsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [CH_W-1:0]   blue,
    input  logic [CH_W-1:0]   green,
    input  logic [CH_W-1:0]   red,
    input  logic [7:0]        f,
    output logic              out_valid,
    output logic [SNUM_W-1:0] out_num,
    output logic [CH_W-1:0]   out_den,
    output pix_t              out_pix
);

    logic             a_valid_reg;
    logic [CH_W-1:0]  a_ch_reg [3];

    logic             b_valid_reg;
    logic [CH_W-1:0]  b_ch_reg [3];
    logic [SUM_W-1:0] b_sum_reg;
    logic [CH_W-1:0]  b_d_reg;
    logic [CH_W-1:0]  b_den_reg;
    logic [17:0]      b_nnum_reg [3];

    logic             c_valid_reg;
    logic [SNUM_W-1:0] c_num_reg;
    logic [CH_W-1:0]  c_den_reg;
    pix_t             c_pix_reg;

    logic [CH_W-1:0]  mx;
    logic [CH_W-1:0]  mn;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] hi_den;
    logic [CH_W-1:0]  den;
    logic [15:0]      s100;
    logic signed [19:0] f_s;
    logic signed [19:0] nn [3];
    logic [17:0]      nnum [3];
    logic [CH_W-1:0]  nres [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_comb
    begin
        mx = a_ch_reg[0];
        mn = a_ch_reg[0];
        for (int i = 1; i < 3; i++)
        begin
            if (a_ch_reg[i] > mx)
            begin
                mx = a_ch_reg[i];
            end
            if (a_ch_reg[i] < mn)
            begin
                mn = a_ch_reg[i];
            end
        end
        sum    = {1'b0, mx} + {1'b0, mn};
        hi_den = 9'd510 - sum;
        den    = (sum < 9'd255) ? sum[7:0] : hi_den[7:0];
        s100   = {7'b0, sum} * 16'd100;
        f_s    = $signed({12'b0, f});
        for (int i = 0; i < 3; i++)
        begin
            nn[i] = $signed({4'b0, s100})
                  + ($signed({11'b0, a_ch_reg[i], 1'b0}) - $signed({11'b0, sum})) * f_s;
            nnum[i] = nn[i][19] ? 18'd0 : nn[i][17:0];
        end
    end

    always_ff @(posedge clk)
    begin
        a_ch_reg[0] <= blue;
        a_ch_reg[1] <= green;
        a_ch_reg[2] <= red;
        b_ch_reg    <= a_ch_reg;
        b_sum_reg   <= sum;
        b_d_reg     <= mx - mn;
        b_den_reg   <= den;
        b_nnum_reg  <= nnum;
    end

    // Rounded division by 200 as a reciprocal multiply on the value shifted by three.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [17:0] n;
            logic [30:0] p;
            n = b_nnum_reg[i] + 18'd100;
            p = {16'b0, n[17:3]} * 31'd41944;
            nres[i] = (p[30:20] > 11'd255) ? 8'd255 : p[27:20];
        end
    end

    always_ff @(posedge clk)
    begin
        c_num_reg      <= {b_d_reg, 16'b0} + {17'b0, b_den_reg[7:1]};
        c_den_reg      <= b_den_reg;
        c_pix_reg.b    <= b_ch_reg[0];
        c_pix_reg.g    <= b_ch_reg[1];
        c_pix_reg.r    <= b_ch_reg[2];
        c_pix_reg.sum  <= b_sum_reg;
        c_pix_reg.gray <= (b_d_reg == 8'd0);
        c_pix_reg.nb   <= nres[0];
        c_pix_reg.ng   <= nres[1];
        c_pix_reg.nr   <= nres[2];
    end

    assign out_valid = c_valid_reg;
    assign out_num   = c_num_reg;
    assign out_den   = c_den_reg;
    assign out_pix   = c_pix_reg;

endmodule

>>> sv/hsa_back.sv
// ----------------------------------------------------------------------------
// HSL saturation adjust back end
// Applies the boost factor, rounds, saturates and selects the branch.
// ----------------------------------------------------------------------------
module hsa_back
    import hsa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [INV_W-1:0] in_inv,
    input  pix_t             in_pix,
    input  logic             inc_pos,
    output logic             done,
    output logic [CH_W-1:0]  blue,
    output logic [CH_W-1:0]  green,
    output logic [CH_W-1:0]  red
);

    logic               p_valid_reg;
    pix_t               p_pix_reg;
    logic signed [35:0] p_prod_reg [3];

    logic               q_valid_reg;
    logic [CH_W-1:0]    q_ch_reg [3];

    logic signed [24:0] alpha;
    logic signed [35:0] alpha36;
    logic signed [35:0] prod [3];
    logic [CH_W-1:0]    pch [3];
    logic [CH_W-1:0]    nch [3];
    logic [CH_W-1:0]    res [3];

    always_comb
    begin
        alpha   = $signed({1'b0, in_inv}) - 25'sd65536;
        alpha36 = {{11{alpha[24]}}, alpha};
        prod[0] = ($signed({27'b0, in_pix.b, 1'b0}) - $signed({27'b0, in_pix.sum})) * alpha36;
        prod[1] = ($signed({27'b0, in_pix.g, 1'b0}) - $signed({27'b0, in_pix.sum})) * alpha36;
        prod[2] = ($signed({27'b0, in_pix.r, 1'b0}) - $signed({27'b0, in_pix.sum})) * alpha36;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= in_valid;
            q_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_pix_reg  <= in_pix;
        p_prod_reg <= prod;
    end

    always_comb
    begin
        pch[0] = p_pix_reg.b;
        pch[1] = p_pix_reg.g;
        pch[2] = p_pix_reg.r;
        nch[0] = p_pix_reg.nb;
        nch[1] = p_pix_reg.ng;
        nch[2] = p_pix_reg.nr;
        for (int i = 0; i < 3; i++)
        begin
            logic signed [35:0] num;
            logic [34:0]        rnd;
            logic [CH_W-1:0]    pos;
            num = $signed({11'b0, pch[i], 17'b0}) + p_prod_reg[i];
            rnd = num[34:0] + 35'd65536;
            if (num[35])
            begin
                pos = 8'd0;
            end
            else if (rnd[34:17] > 18'd255)
            begin
                pos = 8'd255;
            end
            else
            begin
                pos = rnd[24:17];
            end
            if (p_pix_reg.gray)
            begin
                res[i] = pch[i];
            end
            else if (inc_pos)
            begin
                res[i] = pos;
            end
            else
            begin
                res[i] = nch[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_ch_reg <= res;
    end

    assign done  = q_valid_reg;
    assign blue  = q_ch_reg[0];
    assign green = q_ch_reg[1];
    assign red   = q_ch_reg[2];

endmodule

>>> sv/hsl_saturation_adjust.sv
// ----------------------------------------------------------------------------
// HSL saturation adjust
// One pixel is taken every cycle; busy is always low and the result is never held.
// The latency is set mostly by the two pipelined dividers, one quotient bit per stage.
// Reset clears all valid bits and sets the increment to 50 percent.
// ----------------------------------------------------------------------------
module hsl_saturation_adjust
    import hsa_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [CH_W-1:0] blue_in,
    input  logic [CH_W-1:0] green_in,
    input  logic [CH_W-1:0] red_in,
    input  logic            cfg_wr_en,
    input  logic [7:0]      cfg_wr_data,
    output logic            done,
    output logic [CH_W-1:0] blue_out,
    output logic [CH_W-1:0] green_out,
    output logic [CH_W-1:0] red_out
);

    logic              inc_pos_reg;
    logic [7:0]        f_reg;
    logic [SQ_W-1:0]   t_reg;

    logic signed [7:0] inc_clamp;
    logic [6:0]        x;
    logic [11:0]       y;
    logic [30:0]       yq;
    logic [SQ_W-1:0]   t_next;
    logic [7:0]        f_next;

    logic              fe_valid;
    logic [SNUM_W-1:0] fe_num;
    logic [CH_W-1:0]   fe_den;
    pix_t              fe_pix;

    logic              d1_valid;
    logic [SQ_W-1:0]   d1_quo;
    pix_t              d1_pix;

    logic              m_valid_reg;
    logic [INUM_W-1:0] m_num_reg;
    logic [SQ_W-1:0]   m_den_reg;
    pix_t              m_pix_reg;
    logic [SQ_W-1:0]   m_val;

    logic              d2_valid;
    logic [INV_W-1:0]  d2_quo;
    pix_t              d2_pix;

    assign busy = 1'b0;

    // Threshold round(x*65536/100) with x = 100 - max(inc,0) is x*655 + round(x*0.36).
    always_comb
    begin
        if ($signed(cfg_wr_data) > INC_MAX)
        begin
            inc_clamp = INC_MAX;
        end
        else if ($signed(cfg_wr_data) < INC_MIN)
        begin
            inc_clamp = INC_MIN;
        end
        else
        begin
            inc_clamp = $signed(cfg_wr_data);
        end
        x      = inc_clamp[7] ? 7'd100 : 7'(8'sd100 - inc_clamp);
        y      = {5'b0, x} * 12'd36 + 12'd50;
        yq     = {19'b0, y} * 31'd5243;
        t_next = {10'b0, x} * 17'd655 + {10'b0, yq[25:19]};
        f_next = 8'(8'sd100 + inc_clamp);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_pos_reg <= 1'b1;
            f_reg       <= F_RESET;
            t_reg       <= T_RESET;
        end
        else if (cfg_wr_en)
        begin
            inc_pos_reg <= (inc_clamp > 8'sd0);
            f_reg       <= f_next;
            t_reg       <= t_next;
        end
    end

    hsa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .blue      (blue_in),
        .green     (green_in),
        .red       (red_in),
        .f         (f_reg),
        .out_valid (fe_valid),
        .out_num   (fe_num),
        .out_den   (fe_den),
        .out_pix   (fe_pix)
    );

    hsa_div_pipe #(
        .NUM_W (SNUM_W),
        .DEN_W (CH_W),
        .QUO_W (SQ_W),
        .SB_W  ($bits(pix_t))
    ) u_sat_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fe_valid),
        .in_num    (fe_num),
        .in_den    (fe_den),
        .in_sb     (fe_pix),
        .out_valid (d1_valid),
        .out_quo   (d1_quo),
        .out_sb    (d1_pix)
    );

    assign m_val = (d1_quo > t_reg) ? d1_quo : t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        m_num_reg <= {1'b1, 32'b0} + {17'b0, m_val[SQ_W-1:1]};
        m_den_reg <= m_val;
        m_pix_reg <= d1_pix;
    end

    hsa_div_pipe #(
        .NUM_W (INUM_W),
        .DEN_W (SQ_W),
        .QUO_W (INV_W),
        .SB_W  ($bits(pix_t))
    ) u_inv_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m_valid_reg),
        .in_num    (m_num_reg),
        .in_den    (m_den_reg),
        .in_sb     (m_pix_reg),
        .out_valid (d2_valid),
        .out_quo   (d2_quo),
        .out_sb    (d2_pix)
    );

    hsa_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (d2_valid),
        .in_inv   (d2_quo),
        .in_pix   (d2_pix),
        .inc_pos  (inc_pos_reg),
        .done     (done),
        .blue     (blue_out),
        .green    (green_out),
        .red      (red_out)
    );

endmodule
